// ===== design/nlcs_pkg.sv =====
// Nested-loop command sequencer: shared types and constants.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none
package nlcs_pkg;

	localparam int ADDR_IN_W = 10;
	localparam int WORD_W    = 32;
	localparam int FIELD_W   = 16;
	localparam int DEPTH_W   = 4;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_STEP    = 2'd2;

	localparam logic [FIELD_W-1:0] OPEN_MARK     = 16'h8000;
	localparam logic [FIELD_W-1:0] CLOSE_MARK    = 16'h0000;
	localparam logic [FIELD_W-1:0] FOREVER_COUNT = 16'hFFFF;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_NO_LOOP = 2'd1,
		FAULT_NEST    = 2'd2,
		FAULT_FETCH   = 2'd3
	} fault_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDR,
		S_FETCH,
		S_EXEC,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [ADDR_IN_W-1:0] word_address;
		logic [WORD_W-1:0]    word_data;
	} cmd_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] dir_and_delay;
		fault_t             fault;
	} rsp_item_t;

	typedef struct packed {
		logic   load;
		logic   reduce;
		logic   mem_we;
		logic   restart;
		logic   mem_re;
		logic   fetch_clr;
		logic   fetch_inc;
		logic   exec_word;
		logic   out_load;
		fault_t out_fault;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       addr_big;
		logic       is_open;
		logic       is_close;
		logic       stack_full;
		logic       stack_empty;
		logic       fetch_last;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/nlcs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module nlcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/nlcs_ctrl.sv =====
// Sequencer controller: state machine that drives the datapath commands.
// Depends on nlcs_pkg.
`default_nettype none
module nlcs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire nlcs_pkg::dp_status_t st,
	output nlcs_pkg::dp_cmd_t        dc
);
	import nlcs_pkg::*;

	state_t state_q, state_d;
	fault_t fault_q, fault_d;
	logic   fin;
	fault_t fcode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		fault_q <= fault_d;
	end

	always_comb begin
		state_d   = state_q;
		fault_d   = fault_q;
		cmd_ready = 1'b0;
		dc        = '0;
		fin       = 1'b0;
		fcode     = FAULT_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					dc.load = 1'b1;
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				unique case (st.command)
					CMD_STEP: begin
						dc.fetch_clr = 1'b1;
						state_d      = S_FETCH;
					end
					CMD_WRITE: begin
						if (st.addr_big) begin
							dc.reduce = 1'b1;
						end else begin
							dc.mem_we = 1'b1;
							state_d   = S_IDLE;
						end
					end
					CMD_RESTART: begin
						if (st.addr_big) begin
							dc.reduce = 1'b1;
						end else begin
							dc.restart = 1'b1;
							state_d    = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FETCH: begin
				dc.mem_re = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (st.is_open && st.stack_full) begin
					fin   = 1'b1;
					fcode = FAULT_NEST;
				end else if (st.is_close && st.stack_empty) begin
					fin   = 1'b1;
					fcode = FAULT_NO_LOOP;
				end else begin
					dc.exec_word = 1'b1;
					if (!st.is_open && !st.is_close) begin
						fin = 1'b1;
					end else if (st.fetch_last) begin
						fin   = 1'b1;
						fcode = FAULT_FETCH;
					end else begin
						dc.fetch_inc = 1'b1;
						state_d      = S_FETCH;
					end
				end
				fault_d = fcode;
				if (fin) begin
					if (st.out_free) begin
						dc.out_load  = 1'b1;
						dc.out_fault = fcode;
						state_d      = S_IDLE;
					end else begin
						state_d = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (st.out_free) begin
					dc.out_load  = 1'b1;
					dc.out_fault = fault_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/nlcs_dp.sv =====
// Sequencer datapath: program RAM, position, repeat counter, nest stack,
// fetch counter and result register. Depends on nlcs_pkg and nlcs_ram.
`default_nettype none
module nlcs_dp #(
	parameter int PROGRAM_WORDS = 1024,
	parameter int NEST_DEPTH    = 14,
	parameter int MAX_FETCHES   = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nlcs_pkg::cmd_item_t  cmd,
	input  wire nlcs_pkg::dp_cmd_t    dc,
	output nlcs_pkg::dp_status_t      st,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output nlcs_pkg::rsp_item_t       rsp
);
	import nlcs_pkg::*;

	localparam int AW = $clog2(PROGRAM_WORDS);
	localparam int XW = (AW + 1 > ADDR_IN_W) ? AW + 1 : ADDR_IN_W;
	localparam int SW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int FW = $clog2(MAX_FETCHES);

	logic [1:0]          command_q;
	logic [XW-1:0]       addr_q;
	logic [WORD_W-1:0]   data_q;
	logic [AW-1:0]       pos_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [FIELD_W-1:0]  repeat_q;
	logic [FW-1:0]       fcnt_q;
	logic [FIELD_W-1:0]  counts_q [NEST_DEPTH];
	logic [AW-1:0]       starts_q [NEST_DEPTH];
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	logic [WORD_W-1:0]   word;
	logic [FIELD_W-1:0]  wcount;
	logic [FIELD_W-1:0]  wdelay;
	logic [AW-1:0]       pos_next;
	logic [DEPTH_W-1:0]  depth_m1;
	logic [SW-1:0]       top_idx;
	logic [SW-1:0]       push_idx;
	logic [AW-1:0]       addr_idx;
	logic                is_open;
	logic                is_close;
	logic                out_free;

	nlcs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PROGRAM_WORDS)
	) u_prog (
		.clk   (clk),
		.we    (dc.mem_we),
		.waddr (addr_idx),
		.wdata (data_q),
		.re    (dc.mem_re),
		.raddr (pos_q),
		.rdata (word)
	);

	assign wcount   = word[WORD_W-1:FIELD_W];
	assign wdelay   = word[FIELD_W-1:0];
	assign is_open  = (wdelay == OPEN_MARK);
	assign is_close = (wdelay == CLOSE_MARK);
	assign pos_next = (pos_q == AW'(PROGRAM_WORDS - 1)) ? '0 : pos_q + AW'(1);
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign top_idx  = depth_m1[SW-1:0];
	assign push_idx = depth_q[SW-1:0];
	assign addr_idx = addr_q[AW-1:0];
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		st             = '0;
		st.command     = command_q;
		st.addr_big    = (addr_q >= XW'(PROGRAM_WORDS));
		st.is_open     = is_open;
		st.is_close    = is_close;
		st.stack_full  = (depth_q == DEPTH_W'(NEST_DEPTH));
		st.stack_empty = (depth_q == '0);
		st.fetch_last  = (fcnt_q == FW'(MAX_FETCHES - 1));
		st.out_free    = out_free;
	end

	always_ff @(posedge clk) begin
		if (dc.load) begin
			command_q <= cmd.command;
			addr_q    <= XW'(cmd.word_address);
			data_q    <= cmd.word_data;
		end else if (dc.reduce) begin
			addr_q <= addr_q - XW'(PROGRAM_WORDS);
		end
		if (dc.exec_word) begin
			if (is_open) begin
				counts_q[push_idx] <= wcount;
				starts_q[push_idx] <= pos_next;
			end else if (is_close) begin
				if (counts_q[top_idx] != '0 && counts_q[top_idx] != FOREVER_COUNT) begin
					counts_q[top_idx] <= counts_q[top_idx] - FIELD_W'(1);
				end
			end
		end
		if (dc.out_load) begin
			rsp_q.fault         <= dc.out_fault;
			rsp_q.dir_and_delay <= (dc.out_fault == FAULT_NONE) ? wdelay : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			depth_q     <= '0;
			repeat_q    <= '0;
			fcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dc.restart) begin
				pos_q    <= addr_idx;
				depth_q  <= '0;
				repeat_q <= '0;
			end else if (dc.exec_word) begin
				if (is_open) begin
					depth_q <= depth_q + DEPTH_W'(1);
					pos_q   <= pos_next;
				end else if (is_close) begin
					if (counts_q[top_idx] != '0) begin
						pos_q <= starts_q[top_idx];
					end else begin
						depth_q <= depth_m1;
						pos_q   <= pos_next;
					end
				end else if (repeat_q != '0) begin
					if (repeat_q == FIELD_W'(1)) begin
						pos_q <= pos_next;
					end
					repeat_q <= repeat_q - FIELD_W'(1);
				end else if (wcount == '0) begin
					pos_q <= pos_next;
				end else begin
					repeat_q <= wcount;
				end
			end
			if (dc.fetch_clr) begin
				fcnt_q <= '0;
			end else if (dc.fetch_inc) begin
				fcnt_q <= fcnt_q + FW'(1);
			end
			if (dc.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== design/nested_loop_command_sequencer.sv =====
// Nested-loop motion command sequencer, top level.
// Joins the controller (nlcs_ctrl) and datapath (nlcs_dp); depends on nlcs_pkg.
//
// Usage:
//  cmd channel (valid/ready) carries one transaction: write a program word,
//  restart at a word address, or step. Command 3 is ignored.
//  rsp channel (valid/ready) returns one transaction for each step: the
//  delay field of the regular word reached, or a fault code with delay 0.
//  Timing: one transaction at a time. Write/restart pass a load state and
//  an address state, which repeats, subtracting PROGRAM_WORDS, while the
//  address is beyond the program size. A step clears the fetch counter,
//  then fetches and decodes each program word (1..MAX_FETCHES words), one
//  read per fetch from the program RAM with its registered read, and loads
//  the result into an output register, so a new command is taken while a
//  result waits; a step that finishes while the receiver stalls holds
//  until the register frees.
//  Reset clears position, nest depth and repeat count; program memory and
//  the nest stack hold no defined value until written.
`default_nettype none
module nested_loop_command_sequencer #(
	parameter int PROGRAM_WORDS = 1024,
	parameter int NEST_DEPTH    = 14,
	parameter int MAX_FETCHES   = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire nlcs_pkg::cmd_item_t cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output nlcs_pkg::rsp_item_t      rsp
);
	import nlcs_pkg::*;

	dp_cmd_t    dc;
	dp_status_t st;

	nlcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.st        (st),
		.dc        (dc)
	);

	nlcs_dp #(
		.PROGRAM_WORDS (PROGRAM_WORDS),
		.NEST_DEPTH    (NEST_DEPTH),
		.MAX_FETCHES   (MAX_FETCHES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dc        (dc),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for nested_loop_command_sequencer: sends write/restart/step transactions,
// predicts every delay or fault with a behavioral copy of the sequencer and checks each response.
// Depends on nlcs_pkg and the sequencer RTL.
module tb_top;
	import nlcs_pkg::*;

	localparam int PROG_WORDS  = 1024;
	localparam int NEST_LEVELS = 14;
	localparam int FETCH_LIMIT = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_LEN    = 300;
	localparam int DRAIN_WAIT  = 2 * FETCH_LIMIT + 20;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// fixed regions of the initial program image
	localparam int OVF_BASE   = 960;
	localparam int SPIN_BASE  = 980;
	localparam int SLOW_BASE  = 985;
	localparam int LONE_CLOSE = 990;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_req      = 1'b0;
	int   hold_cycles   = 0;
	int   cycle_count   = 0;
	int   mismatches    = 0;
	int   issued_cmds   = 0;

	// predicted sequencer state
	logic [31:0] prog_mem [PROG_WORDS];
	logic [9:0]  cur_pos;
	int          nest_level;
	logic [15:0] repeats_left;
	logic [15:0] loop_cnt [NEST_LEVELS];
	logic [9:0]  loop_start [NEST_LEVELS];

	rsp_item_t   expected_delays [$];
	rsp_item_t   want;
	logic [31:0] program_words [$];

	nested_loop_command_sequencer #(
		.PROGRAM_WORDS(PROG_WORDS),
		.NEST_DEPTH(NEST_LEVELS),
		.MAX_FETCHES(FETCH_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req)
			hold_cycles <= HOLD_LEN;
		else if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_delays.size() == 0) begin
				$error("unexpected response: dir_and_delay %0h fault %0d",
					rsp.dir_and_delay, rsp.fault);
				mismatches++;
			end else begin
				want = expected_delays.pop_front();
				if (rsp.dir_and_delay !== want.dir_and_delay) begin
					$error("dir_and_delay: expected %0h, got %0h",
						want.dir_and_delay, rsp.dir_and_delay);
					mismatches++;
				end
				if (rsp.fault !== want.fault) begin
					$error("fault: expected %0d, got %0d", want.fault, rsp.fault);
					mismatches++;
				end
			end
		end
		rsp_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void advance_program(cmd_item_t c);
		logic [31:0] w;
		logic [15:0] cnt;
		logic [15:0] dly;
		rsp_item_t   r;
		int          n;
		bit          done;
		case (c.command)
			CMD_WRITE: prog_mem[c.word_address] = c.word_data;
			CMD_RESTART: begin
				cur_pos = c.word_address;
				nest_level = 0;
				repeats_left = '0;
			end
			CMD_STEP: begin
				r.dir_and_delay = '0;
				r.fault = FAULT_FETCH;
				done = 1'b0;
				for (n = 0; n < FETCH_LIMIT && !done; n++) begin
					w = prog_mem[cur_pos];
					cnt = w[31:16];
					dly = w[15:0];
					if (dly == OPEN_MARK) begin
						if (nest_level >= NEST_LEVELS) begin
							r.fault = FAULT_NEST;
							done = 1'b1;
						end else begin
							loop_cnt[nest_level] = cnt;
							loop_start[nest_level] = cur_pos + 10'd1;
							nest_level++;
							cur_pos = cur_pos + 10'd1;
						end
					end else if (dly == CLOSE_MARK) begin
						if (nest_level == 0) begin
							r.fault = FAULT_NO_LOOP;
							done = 1'b1;
						end else if (loop_cnt[nest_level-1] != 0) begin
							cur_pos = loop_start[nest_level-1];
							if (loop_cnt[nest_level-1] != FOREVER_COUNT)
								loop_cnt[nest_level-1] = loop_cnt[nest_level-1] - 16'd1;
						end else begin
							nest_level--;
							cur_pos = cur_pos + 10'd1;
						end
					end else begin
						if (repeats_left != 0) begin
							if (repeats_left == 16'd1)
								cur_pos = cur_pos + 10'd1;
							repeats_left = repeats_left - 16'd1;
						end else if (cnt == 0) begin
							cur_pos = cur_pos + 10'd1;
						end else begin
							repeats_left = cnt;
						end
						r.dir_and_delay = dly;
						r.fault = FAULT_NONE;
						done = 1'b1;
					end
				end
				expected_delays.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task automatic send_cmd(logic [1:0] op, logic [9:0] addr, logic [31:0] data);
		cmd_item_t item;
		item.command = op;
		item.word_address = addr;
		item.word_data = data;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		advance_program(item);
		if (op != CMD_UNUSED)
			issued_cmds++;
	endtask

	task automatic write_word(logic [9:0] addr, logic [31:0] data);
		send_cmd(CMD_WRITE, addr, data);
	endtask

	task automatic restart_at(logic [9:0] addr);
		send_cmd(CMD_RESTART, addr, 32'($urandom));
	endtask

	task automatic step();
		send_cmd(CMD_STEP, 10'($urandom), 32'($urandom));
	endtask

	function automatic logic [31:0] regular_word();
		logic [15:0] d;
		logic [15:0] c;
		int          r;
		do
			d = 16'($urandom);
		while (d == OPEN_MARK || d == CLOSE_MARK);
		r = $urandom_range(99);
		if (r < 70)
			c = '0;
		else if (r < 98)
			c = 16'($urandom_range(3, 1));
		else
			c = 16'($urandom);
		return {c, d};
	endfunction

	function automatic logic [31:0] open_word();
		logic [15:0] c;
		int          r;
		r = $urandom_range(99);
		if (r < 50)
			c = 16'($urandom_range(2));
		else if (r < 85)
			c = 16'($urandom_range(8, 3));
		else if (r < 95)
			c = FOREVER_COUNT;
		else
			c = 16'($urandom);
		return {c, OPEN_MARK};
	endfunction

	function automatic logic [31:0] close_word();
		return {16'($urandom), CLOSE_MARK};
	endfunction

	function automatic logic [31:0] fill_word(int a);
		if (a >= OVF_BASE && a <= OVF_BASE + NEST_LEVELS)
			return {16'(a - OVF_BASE), OPEN_MARK};
		else if (a == SPIN_BASE)
			return {FOREVER_COUNT, OPEN_MARK};
		else if (a == SLOW_BASE)
			return {16'd100, OPEN_MARK};
		else if (a == SPIN_BASE + 1 || a == SLOW_BASE + 1 || a == LONE_CLOSE)
			return close_word();
		else
			return regular_word();
	endfunction

	function automatic void build_program(int len, int max_nest, int open_pct, bit noisy);
		int lvl;
		int k;
		int r;
		program_words.delete();
		lvl = 0;
		for (k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (noisy && r < 8) begin
				program_words.push_back($urandom);
			end else if (r < open_pct && lvl < max_nest) begin
				program_words.push_back(open_word());
				lvl++;
			end else if (r < open_pct + 15 && (lvl > 0 || (noisy && r[0]))) begin
				program_words.push_back(close_word());
				if (lvl > 0)
					lvl--;
			end else begin
				program_words.push_back(regular_word());
			end
		end
		// broken sequences may leave loops open
		for (; lvl > 0; lvl--)
			if (!(noisy && $urandom_range(3) == 0))
				program_words.push_back(close_word());
	endfunction

	task automatic run_program();
		bit   noisy;
		bit   deep;
		int   len;
		int   base;
		int   steps;
		int   k;
		int   r;
		noisy = $urandom_range(99) < 20;
		deep = noisy && $urandom_range(3) == 0;
		if (deep) begin
			len = $urandom_range(30, 18);
			build_program(len, NEST_LEVELS + 2, 70, noisy);
		end else begin
			len = $urandom_range(24, 2);
			build_program(len, $urandom_range(4, 1), 20, noisy);
		end
		base = $urandom_range(PROG_WORDS - 1);
		foreach (program_words[k])
			write_word(10'(base + k), program_words[k]);
		restart_at(10'(base));
		steps = $urandom_range(3 * len + 4, 1);
		for (k = 0; k < steps; k++) begin
			r = $urandom_range(99);
			if (r < 3)
				send_cmd(CMD_UNUSED, 10'($urandom), $urandom);
			else if (noisy && r < 6)
				restart_at(10'($urandom));
			else if (noisy && r < 9)
				write_word(10'(base + $urandom_range(len - 1)),
					r[0] ? regular_word() : $urandom);
			step();
		end
	endtask

	task automatic test_fill_memory();
		int a;
		for (a = 0; a < PROG_WORDS; a++)
			write_word(10'(a), fill_word(a));
	endtask

	task automatic test_directed_cases();
		write_word(10'd1023, {16'h0000, 16'hFFFF});
		restart_at(10'd1023);
		step();
		step();
		write_word(10'd512, 32'hFFFF_FFFF);
		restart_at(10'd512);
		step();
		step();
		write_word(10'd513, 32'h0000_0000);
		restart_at(10'd513);
		step();
		step();
		send_cmd(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
		step();
		restart_at(10'(OVF_BASE));
		step();
		step();
		restart_at(10'(SPIN_BASE));
		step();
		step();
		restart_at(10'(SLOW_BASE));
		step();
		step();
		step();
		restart_at(10'(LONE_CLOSE));
		step();
		restart_at(10'd0);
		step();
	endtask

	task automatic test_random_programs(int n);
		int target;
		target = issued_cmds + n;
		while (issued_cmds < target)
			run_program();
	endtask

	task automatic test_output_backpressure();
		int k;
		restart_at(10'($urandom_range(PROG_WORDS - 1)));
		cmd_valid <= 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (k = 0; k < 24; k++)
			step();
	endtask

	initial begin
		cur_pos = '0;
		nest_level = 0;
		repeats_left = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 80;
		test_fill_memory();
		test_directed_cases();
		test_random_programs(180);

		send_idle_pct = 80;
		recv_idle_pct = 33;
		test_random_programs(180);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_backpressure();
		test_random_programs(180);

		cmd_valid <= 1'b0;
		while (expected_delays.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
design/nlcs_pkg.sv
design/nlcs_ram.sv
design/nlcs_ctrl.sv
design/nlcs_dp.sv
design/nested_loop_command_sequencer.sv
verif/tb_top.sv
